// ===== sv/tmcfe_pkg.sv =====
package tmcfe_pkg;

	// item operation codes
	typedef enum logic [2:0] {
		OP_BYTE      = 3'd0,
		OP_OVERRUN   = 3'd1,
		OP_FRAME_ERR = 3'd2,
		OP_BUTTONS   = 3'd3,
		OP_TICK      = 3'd4
	} op_t;

	// operating modes
	typedef enum logic [1:0] {
		MODE_CYCLE = 2'd0,
		MODE_HAND  = 2'd1,
		MODE_FLASH = 2'd2
	} mode_t;

	// road request codes
	localparam logic [1:0] ROAD_NONE = 2'd0;
	localparam logic [1:0] ROAD_ONE  = 2'd1;
	localparam logic [1:0] ROAD_TWO  = 2'd2;

	// character codes
	localparam logic [7:0] PRINTABLE_LOW = 8'd32;
	localparam logic [7:0] CH_NEWLINE    = 8'd10;
	localparam logic [7:0] CH_M          = 8'h4D;
	localparam logic [7:0] CH_A          = 8'h41;
	localparam logic [7:0] CH_N          = 8'h4E;
	localparam logic [7:0] CH_F          = 8'h46;
	localparam logic [7:0] CH_R          = 8'h52;
	localparam logic [7:0] CH_1          = 8'h31;
	localparam logic [7:0] CH_2          = 8'h32;

	// button level bit positions, low means pressed
	localparam int BTN_MODE  = 0;
	localparam int BTN_ROAD1 = 1;
	localparam int BTN_ROAD2 = 2;

	// step auto -> manual -> flashing -> auto
	function automatic logic [1:0] step_mode(input logic [1:0] m);
		logic [1:0] r;
		unique case (m)
			MODE_CYCLE: r = MODE_HAND;
			MODE_HAND:  r = MODE_FLASH;
			MODE_FLASH: r = MODE_CYCLE;
			default:    r = MODE_HAND;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/traffic_mode_command_front_end.sv =====
// A result passes the input register, then the result register; the state update lands
// together with the result. One item per cycle, set by the single-pass update between
// the two registers, unless out_stall holds a valid result in the result register.
// Reset (arst_n low, asynchronous): both stages empty, empty line, auto mode,
// seconds and half-second phase zero, buttons released and both road buttons armed.
module traffic_mode_command_front_end #(
	parameter int LINE_BYTES       = 8,
	parameter int TICKS_PER_SECOND = 2,
	parameter int COUNT_BITS       = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] rx_byte,
	input  logic [2:0] button_levels,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] current_mode,
	output logic       restart,
	output logic [1:0] road_request,
	output logic       clear_other_road,
	output logic [7:0] seconds_count,
	output logic       report_due
);

	localparam int LINE_CAP = LINE_BYTES - 1;
	localparam int LEN_BITS = $clog2(LINE_BYTES);
	localparam int HT_BITS  = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

	// input stage
	logic       valid_s1;
	logic [2:0] op_s1;
	logic [7:0] rx_s1;
	logic [2:0] lv_s1;

	// result stage
	logic       valid_s2;
	logic [1:0] mode_s2;
	logic       restart_s2;
	logic [1:0] road_s2;
	logic       clear_s2;
	logic [7:0] secs_s2;
	logic       report_s2;

	// block state
	logic [LEN_BITS-1:0]   line_len_q;
	logic [7:0]            line_c0_q;
	logic [7:0]            line_c1_q;
	logic [1:0]            mode_q;
	logic [HT_BITS-1:0]    half_q;
	logic [COUNT_BITS-1:0] seconds_q;
	logic [2:0]            last_lv_q;
	logic [1:0]            armed_q;

	// next state and result
	logic [LEN_BITS-1:0]   line_len_d;
	logic [7:0]            line_c0_d;
	logic [7:0]            line_c1_d;
	logic [1:0]            mode_d;
	logic [HT_BITS-1:0]    half_d;
	logic [COUNT_BITS-1:0] seconds_d;
	logic [2:0]            last_lv_d;
	logic [1:0]            armed_d;
	logic                  restart_d;
	logic [1:0]            road_d;
	logic                  clear_d;
	logic                  report_d;

	logic                  advance;
	logic                  do_step;
	logic [LEN_BITS-1:0]   len_eff;
	logic                  fire1;
	logic                  fire2;

	// handshake: stage 1 moves on when the result register is free or drained
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign do_step  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= operation;
			rx_s1 <= rx_byte;
			lv_s1 <= button_levels;
		end
	end

	// single-pass item handling
	always_comb begin
		line_len_d = line_len_q;
		line_c0_d  = line_c0_q;
		line_c1_d  = line_c1_q;
		mode_d     = mode_q;
		half_d     = half_q;
		seconds_d  = seconds_q;
		last_lv_d  = last_lv_q;
		armed_d    = armed_q;
		restart_d  = 1'b0;
		road_d     = tmcfe_pkg::ROAD_NONE;
		clear_d    = 1'b0;
		report_d   = 1'b0;
		fire1      = 1'b0;
		fire2      = 1'b0;
		len_eff    = (op_s1 == tmcfe_pkg::OP_OVERRUN) ? '0 : line_len_q;

		unique case (tmcfe_pkg::op_t'(op_s1))
			tmcfe_pkg::OP_BYTE, tmcfe_pkg::OP_OVERRUN: begin
				if (rx_s1 == tmcfe_pkg::CH_NEWLINE) begin
					// finished line: always report, then match commands
					report_d   = 1'b1;
					line_len_d = '0;
					if (len_eff == LEN_BITS'(1)) begin
						unique case (line_c0_q)
							tmcfe_pkg::CH_M: begin
								mode_d    = tmcfe_pkg::step_mode(mode_q);
								restart_d = 1'b1;
								seconds_d = '0;
							end
							tmcfe_pkg::CH_A: begin
								mode_d    = tmcfe_pkg::MODE_CYCLE;
								restart_d = 1'b1;
								seconds_d = '0;
							end
							tmcfe_pkg::CH_N: begin
								mode_d    = tmcfe_pkg::MODE_HAND;
								restart_d = 1'b1;
								seconds_d = '0;
							end
							tmcfe_pkg::CH_F: begin
								mode_d    = tmcfe_pkg::MODE_FLASH;
								restart_d = 1'b1;
								seconds_d = '0;
							end
							default: begin
							end
						endcase
					end else if (len_eff == LEN_BITS'(2) && line_c0_q == tmcfe_pkg::CH_R
						&& mode_q == tmcfe_pkg::MODE_HAND) begin
						if (line_c1_q == tmcfe_pkg::CH_1) begin
							road_d = tmcfe_pkg::ROAD_ONE;
						end else if (line_c1_q == tmcfe_pkg::CH_2) begin
							road_d = tmcfe_pkg::ROAD_TWO;
						end
					end
				end else if (rx_s1 < tmcfe_pkg::PRINTABLE_LOW) begin
					// control byte restarts the line
					line_len_d = '0;
				end else if (len_eff < LEN_BITS'(LINE_CAP)) begin
					// only the first two characters are ever matched
					if (len_eff == '0) begin
						line_c0_d = rx_s1;
					end
					if (len_eff == LEN_BITS'(1)) begin
						line_c1_d = rx_s1;
					end
					line_len_d = LEN_BITS'(len_eff + 1'b1);
				end else begin
					// overflow drops the byte and restarts the line
					line_len_d = '0;
				end
			end
			tmcfe_pkg::OP_FRAME_ERR: begin
				line_len_d = '0;
			end
			tmcfe_pkg::OP_BUTTONS: begin
				// mode button falling edge steps the mode
				if (last_lv_q[tmcfe_pkg::BTN_MODE] && !lv_s1[tmcfe_pkg::BTN_MODE]) begin
					mode_d    = tmcfe_pkg::step_mode(mode_q);
					restart_d = 1'b1;
					seconds_d = '0;
					report_d  = 1'b1;
				end
				// road buttons: falling edge fires and disarms, rising edge re-arms
				if (last_lv_q[tmcfe_pkg::BTN_ROAD1] && !lv_s1[tmcfe_pkg::BTN_ROAD1]) begin
					fire1      = armed_q[0];
					armed_d[0] = 1'b0;
				end else if (!last_lv_q[tmcfe_pkg::BTN_ROAD1] && lv_s1[tmcfe_pkg::BTN_ROAD1]) begin
					armed_d[0] = 1'b1;
				end
				if (last_lv_q[tmcfe_pkg::BTN_ROAD2] && !lv_s1[tmcfe_pkg::BTN_ROAD2]) begin
					fire2      = armed_q[1];
					armed_d[1] = 1'b0;
				end else if (!last_lv_q[tmcfe_pkg::BTN_ROAD2] && lv_s1[tmcfe_pkg::BTN_ROAD2]) begin
					armed_d[1] = 1'b1;
				end
				last_lv_d = lv_s1;
				// requests use the mode after any mode step, road two wins
				if ((fire1 || fire2) && mode_d == tmcfe_pkg::MODE_HAND) begin
					road_d    = fire2 ? tmcfe_pkg::ROAD_TWO : tmcfe_pkg::ROAD_ONE;
					clear_d   = 1'b1;
					restart_d = 1'b1;
					seconds_d = '0;
					report_d  = 1'b1;
				end
			end
			tmcfe_pkg::OP_TICK: begin
				report_d = 1'b1;
				if (half_q == HT_BITS'(TICKS_PER_SECOND - 1)) begin
					half_d    = '0;
					seconds_d = seconds_q + 1'b1;
				end else begin
					half_d = half_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// state update on each transfer out of stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			mode_q     <= tmcfe_pkg::MODE_CYCLE;
			half_q     <= '0;
			seconds_q  <= '0;
			last_lv_q  <= '1;
			armed_q    <= '1;
		end else if (do_step) begin
			line_len_q <= line_len_d;
			mode_q     <= mode_d;
			half_q     <= half_d;
			seconds_q  <= seconds_d;
			last_lv_q  <= last_lv_d;
			armed_q    <= armed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			line_c0_q <= line_c0_d;
			line_c1_q <= line_c1_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			mode_s2    <= mode_d;
			restart_s2 <= restart_d;
			road_s2    <= road_d;
			clear_s2   <= clear_d;
			secs_s2    <= 8'(seconds_d);
			report_s2  <= report_d;
		end
	end

	assign out_valid        = valid_s2;
	assign current_mode     = mode_s2;
	assign restart          = restart_s2;
	assign road_request     = road_s2;
	assign clear_other_road = clear_s2;
	assign seconds_count    = secs_s2;
	assign report_due       = report_s2;

	// checks
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && restart_s2 |-> secs_s2 == 8'd0 && report_s2)
		else $error("restart without cleared seconds or report");

	a_clear_has_road: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && clear_s2 |-> road_s2 != tmcfe_pkg::ROAD_NONE)
		else $error("clear_other_road without a road request");

	a_road_manual: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && road_s2 != tmcfe_pkg::ROAD_NONE |-> mode_s2 == tmcfe_pkg::MODE_HAND)
		else $error("road request outside manual mode");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled while the pipeline can move");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!do_step |=> $stable(mode_q) && $stable(seconds_q) && $stable(line_len_q))
		else $error("state changed without an item");

endmodule

// ===== verif/tb.sv =====
module tb;

	localparam int LINE_BYTES       = 8;
	localparam int TICKS_PER_SECOND = 2;
	localparam int COUNT_BITS       = 8;
	localparam int LINE_CAP         = LINE_BYTES - 1;
	localparam int TOTAL_ITEMS      = 450;
	localparam int CYCLE_LIMIT      = 200000;

	// code outside the defined operations, the block ignores it
	localparam logic [2:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		tmcfe_pkg::mode_t mode;
		logic             restart;
		logic [1:0]       road;
		logic             clear;
		logic [7:0]       secs;
		logic             report;
	} result_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data;
		logic [2:0] levels;
		logic       pinned;
		result_t    want;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] operation;
	logic [7:0] rx_byte;
	logic [2:0] button_levels;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] current_mode;
	logic       restart;
	logic [1:0] road_request;
	logic       clear_other_road;
	logic [7:0] seconds_count;
	logic       report_due;

	// shadow state of the front end
	logic [7:0]            line_chars [LINE_CAP];
	int                    line_len;
	tmcfe_pkg::mode_t      mode_now;
	int                    half_count;
	logic [COUNT_BITS-1:0] secs_now;
	logic [2:0]            levels_prev;
	logic [1:0]            armed;
	result_t               front_res;

	result_t pending_results [$];
	result_t head_res;
	int      errors;
	int      cycles;
	int      sent_count;
	logic    steady;

	traffic_mode_command_front_end #(
		.LINE_BYTES(LINE_BYTES),
		.TICKS_PER_SECOND(TICKS_PER_SECOND),
		.COUNT_BITS(COUNT_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.rx_byte(rx_byte),
		.button_levels(button_levels),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.current_mode(current_mode),
		.restart(restart),
		.road_request(road_request),
		.clear_other_road(clear_other_road),
		.seconds_count(seconds_count),
		.report_due(report_due)
	);

	// directed items, pinned rows carry a hand-written result
	row_t plan [26] = '{
		// ticks from reset, second tick completes a second
		'{tmcfe_pkg::OP_TICK, 8'h00, 3'b111, 1'b1,
			'{tmcfe_pkg::MODE_CYCLE, 1'b0, tmcfe_pkg::ROAD_NONE, 1'b0, 8'd0, 1'b1}},
		'{tmcfe_pkg::OP_TICK, 8'hFF, 3'b111, 1'b1,
			'{tmcfe_pkg::MODE_CYCLE, 1'b0, tmcfe_pkg::ROAD_NONE, 1'b0, 8'd1, 1'b1}},
		// manual command line
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_N, 3'b111, 1'b1,
			'{tmcfe_pkg::MODE_CYCLE, 1'b0, tmcfe_pkg::ROAD_NONE, 1'b0, 8'd1, 1'b0}},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_NEWLINE, 3'b111, 1'b1,
			'{tmcfe_pkg::MODE_HAND, 1'b1, tmcfe_pkg::ROAD_NONE, 1'b0, 8'd0, 1'b1}},
		// road two from a line in manual mode
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_R, 3'b111, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_2, 3'b111, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_NEWLINE, 3'b111, 1'b1,
			'{tmcfe_pkg::MODE_HAND, 1'b0, tmcfe_pkg::ROAD_TWO, 1'b0, 8'd0, 1'b1}},
		// road buttons one then two, release, then all three at once
		'{tmcfe_pkg::OP_BUTTONS, 8'h00, 3'b101, 1'b1,
			'{tmcfe_pkg::MODE_HAND, 1'b1, tmcfe_pkg::ROAD_ONE, 1'b1, 8'd0, 1'b1}},
		'{tmcfe_pkg::OP_BUTTONS, 8'h00, 3'b001, 1'b1,
			'{tmcfe_pkg::MODE_HAND, 1'b1, tmcfe_pkg::ROAD_TWO, 1'b1, 8'd0, 1'b1}},
		'{tmcfe_pkg::OP_BUTTONS, 8'h00, 3'b111, 1'b1,
			'{tmcfe_pkg::MODE_HAND, 1'b0, tmcfe_pkg::ROAD_NONE, 1'b0, 8'd0, 1'b0}},
		'{tmcfe_pkg::OP_BUTTONS, 8'h00, 3'b000, 1'b1,
			'{tmcfe_pkg::MODE_FLASH, 1'b1, tmcfe_pkg::ROAD_NONE, 1'b0, 8'd0, 1'b1}},
		// overrun byte starts a fresh line
		'{tmcfe_pkg::OP_OVERRUN, tmcfe_pkg::CH_A, 3'b000, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_NEWLINE, 3'b000, 1'b1,
			'{tmcfe_pkg::MODE_CYCLE, 1'b1, tmcfe_pkg::ROAD_NONE, 1'b0, 8'd0, 1'b1}},
		// framing error, top byte, control byte
		'{tmcfe_pkg::OP_FRAME_ERR, 8'hFF, 3'b000, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, 8'hFF, 3'b000, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, 8'h00, 3'b000, 1'b0, '0},
		// fill the line, then overflow drops the next byte
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_M, 3'b000, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_M, 3'b000, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_M, 3'b000, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_M, 3'b000, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_M, 3'b000, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_M, 3'b000, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_M, 3'b000, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_M, 3'b000, 1'b0, '0},
		'{tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_NEWLINE, 3'b000, 1'b1,
			'{tmcfe_pkg::MODE_CYCLE, 1'b0, tmcfe_pkg::ROAD_NONE, 1'b0, 8'd0, 1'b1}},
		// undefined operation leaves everything alone
		'{OP_UNUSED, 8'hFF, 3'b000, 1'b1,
			'{tmcfe_pkg::MODE_CYCLE, 1'b0, tmcfe_pkg::ROAD_NONE, 1'b0, 8'd0, 1'b0}}
	};

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void clear_seconds();
		front_res.restart = 1'b1;
		secs_now = '0;
	endfunction

	function automatic void advance_mode();
		mode_now = (mode_now == tmcfe_pkg::MODE_FLASH) ? tmcfe_pkg::MODE_CYCLE
			: tmcfe_pkg::mode_t'(mode_now + 2'd1);
		clear_seconds();
	endfunction

	// one received byte into the line, newline matches the command
	function automatic void absorb_char(input logic [7:0] b);
		if (b == tmcfe_pkg::CH_NEWLINE) begin
			front_res.report = 1'b1;
			if (line_len == 1 && line_chars[0] == tmcfe_pkg::CH_M) begin
				advance_mode();
			end else if (line_len == 1 && line_chars[0] == tmcfe_pkg::CH_A) begin
				mode_now = tmcfe_pkg::MODE_CYCLE;
				clear_seconds();
			end else if (line_len == 1 && line_chars[0] == tmcfe_pkg::CH_N) begin
				mode_now = tmcfe_pkg::MODE_HAND;
				clear_seconds();
			end else if (line_len == 1 && line_chars[0] == tmcfe_pkg::CH_F) begin
				mode_now = tmcfe_pkg::MODE_FLASH;
				clear_seconds();
			end else if (mode_now == tmcfe_pkg::MODE_HAND && line_len == 2
				&& line_chars[0] == tmcfe_pkg::CH_R) begin
				if (line_chars[1] == tmcfe_pkg::CH_1)
					front_res.road = tmcfe_pkg::ROAD_ONE;
				else if (line_chars[1] == tmcfe_pkg::CH_2)
					front_res.road = tmcfe_pkg::ROAD_TWO;
			end
			line_len = 0;
		end else if (b < tmcfe_pkg::PRINTABLE_LOW) begin
			line_len = 0;
		end else if (line_len < LINE_CAP) begin
			line_chars[line_len] = b;
			line_len++;
		end else begin
			line_len = 0;
		end
	endfunction

	// expected result of one item, updates the shadow state
	function automatic result_t advance_front(input logic [2:0] op, input logic [7:0] b,
			input logic [2:0] lv);
		logic [1:0] fired;
		logic       was;
		logic       now;
		front_res = '0;
		fired = '0;
		unique case (op)
			tmcfe_pkg::OP_BYTE: absorb_char(b);
			tmcfe_pkg::OP_OVERRUN: begin
				line_len = 0;
				absorb_char(b);
			end
			tmcfe_pkg::OP_FRAME_ERR: line_len = 0;
			tmcfe_pkg::OP_BUTTONS: begin
				if (levels_prev[tmcfe_pkg::BTN_MODE] && !lv[tmcfe_pkg::BTN_MODE]) begin
					advance_mode();
					front_res.report = 1'b1;
				end
				// falling edge fires and disarms, rising edge re-arms
				for (int i = 0; i < 2; i++) begin
					was = levels_prev[tmcfe_pkg::BTN_ROAD1 + i];
					now = lv[tmcfe_pkg::BTN_ROAD1 + i];
					if (was && !now) begin
						if (armed[i]) begin
							fired[i] = 1'b1;
							armed[i] = 1'b0;
						end
					end else if (!was && now) begin
						armed[i] = 1'b1;
					end
				end
				levels_prev = lv;
				if (mode_now == tmcfe_pkg::MODE_HAND) begin
					if (fired[0]) begin
						front_res.road = tmcfe_pkg::ROAD_ONE;
						front_res.clear = 1'b1;
						front_res.report = 1'b1;
						clear_seconds();
					end
					if (fired[1]) begin
						front_res.road = tmcfe_pkg::ROAD_TWO;
						front_res.clear = 1'b1;
						front_res.report = 1'b1;
						clear_seconds();
					end
				end
			end
			tmcfe_pkg::OP_TICK: begin
				front_res.report = 1'b1;
				half_count++;
				if (half_count >= TICKS_PER_SECOND) begin
					half_count = 0;
					secs_now = secs_now + 1'b1;
				end
			end
			default: ;
		endcase
		front_res.mode = mode_now;
		front_res.secs = secs_now[7:0];
		return front_res;
	endfunction

	task automatic note_mismatch(input string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
	endtask

	// compare each result transfer with the oldest pending one
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_mismatch("result transfer with nothing pending");
			end else begin
				head_res = pending_results.pop_front();
				check_field("current_mode", current_mode, head_res.mode);
				check_field("restart", restart, head_res.restart);
				check_field("road_request", road_request, head_res.road);
				check_field("clear_other_road", clear_other_road, head_res.clear);
				check_field("seconds_count", seconds_count, head_res.secs);
				check_field("report_due", report_due, head_res.report);
			end
		end
	end

	// result side stall, drawn per transfer
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = steady ? 0 : $urandom_range(0, 6);
			if (hold != 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// one input transfer, called at a falling edge
	task automatic send_item(input logic [2:0] op, input logic [7:0] b, input logic [2:0] lv,
			input logic pinned, input result_t want);
		int      gap;
		result_t predicted;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		rx_byte = b;
		button_levels = lv;
		do @(posedge clk); while (in_stall);
		predicted = advance_front(op, b, lv);
		if (pinned)
			predicted = want;
		pending_results.push_back(predicted);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_chars(input logic [7:0] chars [$], input logic overrun_first);
		for (int i = 0; i < chars.size(); i++)
			send_item((i == 0 && overrun_first) ? tmcfe_pkg::OP_OVERRUN : tmcfe_pkg::OP_BYTE,
				chars[i], 3'($urandom), 1'b0, '0);
	endtask

	// a command line with random content and a random ending
	task automatic send_command();
		logic [7:0] chars [$];
		int         pick;
		int         ending;
		pick = $urandom_range(0, 11);
		unique case (pick)
			0: chars = {tmcfe_pkg::CH_M};
			1: chars = {tmcfe_pkg::CH_A};
			2, 3: chars = {tmcfe_pkg::CH_N};
			4: chars = {tmcfe_pkg::CH_F};
			5, 6: chars = {tmcfe_pkg::CH_R, tmcfe_pkg::CH_1};
			7, 8: chars = {tmcfe_pkg::CH_R, tmcfe_pkg::CH_2};
			9: chars = {tmcfe_pkg::CH_R};
			10: chars = {tmcfe_pkg::CH_R, 8'($urandom_range(32, 255))};
			default: repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(32, 255)));
		endcase
		send_chars(chars, $urandom_range(0, 9) == 0);
		ending = $urandom_range(0, 19);
		if (ending < 17)
			send_item(tmcfe_pkg::OP_BYTE, tmcfe_pkg::CH_NEWLINE, 3'($urandom), 1'b0, '0);
		else if (ending < 19)
			send_item(tmcfe_pkg::OP_BYTE, 8'($urandom_range(0, 31)), 3'($urandom), 1'b0, '0);
		else
			send_item(tmcfe_pkg::OP_FRAME_ERR, 8'($urandom_range(0, 255)), 3'($urandom),
				1'b0, '0);
	endtask

	// a long line, from one short of the line store's capacity to past it
	task automatic send_long_line();
		logic [7:0] chars [$];
		repeat ($urandom_range(LINE_CAP - 1, LINE_CAP + 3))
			chars.push_back(8'($urandom_range(32, 255)));
		chars.push_back(tmcfe_pkg::CH_NEWLINE);
		send_chars(chars, 1'b0);
	endtask

	// stimulus
	initial begin
		int pick;
		in_valid = 1'b0;
		operation = tmcfe_pkg::OP_BYTE;
		rx_byte = 8'h00;
		button_levels = 3'b111;
		steady = 1'b0;
		errors = 0;
		cycles = 0;
		sent_count = 0;
		line_len = 0;
		mode_now = tmcfe_pkg::MODE_CYCLE;
		half_count = 0;
		secs_now = '0;
		levels_prev = 3'b111;
		armed = 2'b11;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < $size(plan); i++)
			send_item(plan[i].op, plan[i].data, plan[i].levels, plan[i].pinned, plan[i].want);

		// random traffic up to the item total
		while (sent_count < TOTAL_ITEMS) begin
			steady = ($urandom_range(0, 9) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_command();
			else if (pick < 52)
				send_item(tmcfe_pkg::OP_BUTTONS, 8'($urandom_range(0, 255)), 3'($urandom),
					1'b0, '0);
			else if (pick < 62)
				send_item(tmcfe_pkg::OP_BUTTONS, 8'($urandom_range(0, 255)), 3'b111, 1'b0, '0);
			else if (pick < 78)
				send_item(tmcfe_pkg::OP_TICK, 8'($urandom_range(0, 255)), 3'($urandom),
					1'b0, '0);
			else if (pick < 86)
				send_long_line();
			else if (pick < 93)
				send_item($urandom_range(0, 1) ? tmcfe_pkg::OP_OVERRUN : tmcfe_pkg::OP_BYTE,
					8'($urandom_range(0, 255)), 3'($urandom), 1'b0, '0);
			else if (pick < 97)
				send_item(tmcfe_pkg::OP_FRAME_ERR, 8'($urandom_range(0, 255)), 3'($urandom),
					1'b0, '0);
			else
				send_item(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)), 3'($urandom),
					1'b0, '0);
		end
		in_valid = 1'b0;
		steady = 1'b0;

		// drain, then watch for stray transfers
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/tmcfe_pkg.sv
sv/traffic_mode_command_front_end.sv
verif/tb.sv
